// File: sv/ftc_pkg.sv
// ftc_pkg: shared constants and the query word that walks the flow cell chain
// used by ftc_cell and five_tuple_flow_counter; no dependencies
`default_nettype none

package ftc_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int COUNT_BITS    = 32;
  localparam int KEY_W         = 104;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int OCC_W         = $clog2(TABLE_ENTRIES + 1);

  // fixed port and result field widths
  localparam int OUT_IDX_W = 6;
  localparam int OUT_CNT_W = 32;
  localparam int OUT_OCC_W = 7;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 48;

  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [OCC_W-1:0]      occ_t;

  // one tuple in flight; done once some cell hit or took it
  typedef struct packed {
    logic vld;
    key_t key;
    logic done;
    logic new_flow;
    idx_t idx;
    cnt_t cnt;
    occ_t occ;
  } query_t;

  localparam cnt_t CNT_MAX = '1;

endpackage

`default_nettype wire

// File: sv/ftc_cell.sv
// ftc_cell: one flow table entry with its key, packet count and occupied flag
// depends on ftc_pkg; compares the passing query and hands it to the next cell
`default_nettype none

module ftc_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire ftc_pkg::idx_t   cell_idx,
  input  wire ftc_pkg::query_t q_i,
  output ftc_pkg::query_t      q_o
);

  logic            occupied_r, occupied_nxt;
  ftc_pkg::key_t   key_r, key_nxt;
  ftc_pkg::cnt_t   cnt_r, cnt_nxt;
  ftc_pkg::query_t q_r, q_nxt;
  logic            live, hit, take;

  assign live = q_i.vld && !q_i.done;
  assign hit  = live && occupied_r && (key_r == q_i.key);
  assign take = live && !occupied_r;

  always_comb begin
    occupied_nxt = occupied_r;
    key_nxt      = key_r;
    cnt_nxt      = cnt_r;
    q_nxt        = q_i;
    if (hit) begin
      if (cnt_r != ftc_pkg::CNT_MAX) begin
        cnt_nxt = cnt_r + ftc_pkg::cnt_t'(1);
      end
      q_nxt.done = 1'b1;
      q_nxt.idx  = cell_idx;
      q_nxt.cnt  = cnt_nxt;
    end else if (take) begin
      occupied_nxt   = 1'b1;
      key_nxt        = q_i.key;
      cnt_nxt        = ftc_pkg::cnt_t'(1);
      q_nxt.done     = 1'b1;
      q_nxt.new_flow = 1'b1;
      q_nxt.idx      = cell_idx;
      q_nxt.cnt      = cnt_nxt;
    end
    // running occupancy as seen after this item
    if (occupied_nxt) begin
      q_nxt.occ = q_i.occ + ftc_pkg::occ_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occupied_r <= 1'b0;
      q_r.vld    <= 1'b0;
    end else if (adv) begin
      occupied_r <= occupied_nxt;
      key_r      <= key_nxt;
      cnt_r      <= cnt_nxt;
      q_r        <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

`default_nettype wire

// File: sv/five_tuple_flow_counter.sv
// each accepted tuple walks the TABLE_ENTRIES cells in order, a register per cell, to the result
// throughput: one tuple per cycle; the whole chain stalls while a result waits
// each item sees every earlier item's update since it trails it by at least one cell
// reset (rst_n low, synchronous): all entries free, occupancy zero, chain empty
// five_tuple_flow_counter: top level, chain of ftc_cell entries and result format
// depends on ftc_pkg and ftc_cell
`default_nettype none

module five_tuple_flow_counter (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // src_ip, dst_ip, src_port, dst_port, proto
  input  wire logic [ftc_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // flow_index, flow_count, new_flow, dropped, unique_flows, one pad bit
  output logic [ftc_pkg::OUT_DATA_W-1:0]      out_tdata
);

  ftc_pkg::query_t q [ftc_pkg::TABLE_ENTRIES+1];
  ftc_pkg::query_t last;
  logic            adv;
  logic            drop;

  // chain moves when the last cell's word is empty or being taken
  assign adv       = !q[ftc_pkg::TABLE_ENTRIES].vld || out_tready;
  assign in_tready = adv;

  always_comb begin
    q[0]          = '0;
    q[0].vld      = in_tvalid;
    q[0].key      = in_tdata;
  end

  for (genvar g = 0; g < ftc_pkg::TABLE_ENTRIES; g++) begin : g_cell
    ftc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (ftc_pkg::IDX_W'(g)),
      .q_i      (q[g]),
      .q_o      (q[g+1])
    );
  end

  assign last       = q[ftc_pkg::TABLE_ENTRIES];
  assign drop       = !last.done;
  assign out_tvalid = last.vld;

  always_comb begin
    out_tdata = '0;
    if (!drop) begin
      out_tdata[5:0]  = ftc_pkg::OUT_IDX_W'(last.idx);
      out_tdata[37:6] = ftc_pkg::OUT_CNT_W'(last.cnt);
    end
    out_tdata[38]    = last.new_flow;
    out_tdata[39]    = drop;
    out_tdata[46:40] = ftc_pkg::OUT_OCC_W'(last.occ);
  end

endmodule

`default_nettype wire

// File: sv/ftc_checker.sv
// ftc_checker: port-level checks on the flow counter's result stream
// depends on nothing but the top level's ports; bound to five_tuple_flow_counter
`default_nettype none

module ftc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[39] |->
      out_tdata[37:0] == 38'd0 && !out_tdata[38] && out_tdata[46:40] == 7'd64)
    else $error("dropped word not clean or table not full");

  a_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[38] |->
      out_tdata[37:6] == 32'd1 && out_tdata[46:40] == {1'b0, out_tdata[5:0]} + 7'd1)
    else $error("new flow word inconsistent");

  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[38] && !out_tdata[39] |->
      out_tdata[37:6] != 32'd0 && {1'b0, out_tdata[5:0]} < out_tdata[46:40])
    else $error("hit word outside occupied entries");

endmodule

bind five_tuple_flow_counter ftc_checker u_ftc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: verif/five_tuple_flow_counter_tb.sv
// five_tuple_flow_counter_tb: self-checking bench for the exact-match flow table,
// directed table of tuples then random hit, miss and near-miss traffic with stalls
// depends on ftc_pkg and five_tuple_flow_counter
module five_tuple_flow_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_WORDS  = 1684;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int IDLE_PCT    = 21;

  // tuple as it sits in in_tdata: src_ip lowest, proto highest
  typedef struct packed {
    logic [7:0]  proto;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [31:0] dst_ip;
    logic [31:0] src_ip;
  } tuple_t;

  // result as it sits in out_tdata: flow_index lowest
  typedef struct packed {
    logic        pad;
    logic [6:0]  unique_flows;
    logic        dropped;
    logic        new_flow;
    logic [31:0] flow_count;
    logic [5:0]  flow_index;
  } flow_result_t;

  typedef struct packed {
    tuple_t       t;
    logic         typed;
    flow_result_t r;
  } stim_row_t;

  // tuple (proto, dst_port, src_port, dst_ip, src_ip), typed flag,
  // result (pad, unique_flows, dropped, new_flow, flow_count, flow_index)
  localparam stim_row_t STIM_ROWS [16] = '{
    {8'h00, 16'h0000, 16'h0000, 32'h00000000, 32'h00000000, 1'b1,
     1'b0, 7'd1, 1'b0, 1'b1, 32'd1, 6'd0},
    {8'h00, 16'h0000, 16'h0000, 32'h00000000, 32'h00000000, 1'b1,
     1'b0, 7'd1, 1'b0, 1'b0, 32'd2, 6'd0},
    {8'hff, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff, 1'b1,
     1'b0, 7'd2, 1'b0, 1'b1, 32'd1, 6'd1},
    {8'hff, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff, 1'b1,
     1'b0, 7'd2, 1'b0, 1'b0, 32'd2, 6'd1},
    // tuples that differ from the zero or the all-ones flow in one field only, and repeats
    {8'h01, 16'h0000, 16'h0000, 32'h00000000, 32'h00000000, 1'b1,
     1'b0, 7'd3, 1'b0, 1'b1, 32'd1, 6'd2},
    {8'h00, 16'hffff, 16'h0000, 32'h00000000, 32'h00000000, 1'b1,
     1'b0, 7'd4, 1'b0, 1'b1, 32'd1, 6'd3},
    {8'h00, 16'h0000, 16'h0001, 32'h00000000, 32'h00000000, 1'b1,
     1'b0, 7'd5, 1'b0, 1'b1, 32'd1, 6'd4},
    {8'h00, 16'h0000, 16'h0000, 32'h80000000, 32'h00000000, 1'b1,
     1'b0, 7'd6, 1'b0, 1'b1, 32'd1, 6'd5},
    {8'h00, 16'h0000, 16'h0000, 32'h00000000, 32'h00000001, 1'b1,
     1'b0, 7'd7, 1'b0, 1'b1, 32'd1, 6'd6},
    {8'h00, 16'h0000, 16'h0000, 32'h00000000, 32'h00000000, 1'b1,
     1'b0, 7'd7, 1'b0, 1'b0, 32'd3, 6'd0},
    {8'h00, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff, 1'b1,
     1'b0, 7'd8, 1'b0, 1'b1, 32'd1, 6'd7},
    {8'hff, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff, 1'b1,
     1'b0, 7'd8, 1'b0, 1'b0, 32'd3, 6'd1},
    // back to back repeats of one flow, then two other flows
    {8'h06, 16'h0050, 16'hc350, 32'h0a000001, 32'hc0a80101, 1'b0, 48'h0},
    {8'h06, 16'h0050, 16'hc350, 32'h0a000001, 32'hc0a80101, 1'b0, 48'h0},
    {8'h11, 16'h0035, 16'h1234, 32'h08080808, 32'hc0a80102, 1'b0, 48'h0},
    {8'h01, 16'h0000, 16'h0000, 32'h00000000, 32'h00000000, 1'b0, 48'h0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ftc_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ftc_pkg::OUT_DATA_W-1:0] out_tdata;

  // side info that travels with the word on the input side
  logic         word_typed = 1'b0;
  flow_result_t word_want = '0;

  // flow table as the bench sees it
  tuple_t        tbl_key [ftc_pkg::TABLE_ENTRIES];
  ftc_pkg::cnt_t tbl_cnt [ftc_pkg::TABLE_ENTRIES];
  int            tbl_used = 0;

  flow_result_t due_results [$];
  int  error_count = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;
  bit  hold_taken = 1'b0;
  int  hold_left = 0;

  five_tuple_flow_counter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lookup, then bump the count or append the tuple or drop it
  function automatic flow_result_t count_flow(input tuple_t t);
    flow_result_t r;
    int hit;
    r = '0;
    hit = -1;
    for (int i = 0; i < tbl_used; i++) begin
      if (hit < 0 && tbl_key[i] == t) hit = i;
    end
    if (hit >= 0) begin
      if (tbl_cnt[hit] != ftc_pkg::CNT_MAX) tbl_cnt[hit] = tbl_cnt[hit] + 1'b1;
      r.flow_index = 6'(hit);
      r.flow_count = 32'(tbl_cnt[hit]);
    end else if (tbl_used < ftc_pkg::TABLE_ENTRIES) begin
      tbl_key[tbl_used] = t;
      tbl_cnt[tbl_used] = ftc_pkg::cnt_t'(1);
      r.flow_index = 6'(tbl_used);
      r.flow_count = 32'd1;
      r.new_flow = 1'b1;
      tbl_used++;
    end else begin
      r.dropped = 1'b1;
    end
    r.unique_flows = 7'(tbl_used);
    return r;
  endfunction

  // mostly hits on stored flows, plus fresh tuples, repeats and one-bit near misses
  function automatic tuple_t pick_tuple(input tuple_t prev);
    logic [31:0] a, b, c, d;
    int roll;
    tuple_t t;
    a = $urandom;
    b = $urandom;
    c = $urandom;
    d = $urandom;
    roll = $urandom_range(99);
    t = {d[7:0], c, b, a};
    if (tbl_used == 0 || roll < 20) return t;
    if (roll < 30) return prev;
    t = tbl_key[$urandom_range(tbl_used - 1)];
    if (roll < 45) t = t ^ (104'd1 << $urandom_range(ftc_pkg::KEY_W - 1));
    return t;
  endfunction

  task automatic offer_word(input tuple_t t, input logic typed, input flow_result_t want);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= t;
    word_typed <= typed;
    word_want  <= want;
    do @(posedge clk); while (!in_tready);
  endtask

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (idle_on) begin
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // predict on input accept, check on output accept
  always @(posedge clk) begin
    flow_result_t pred, want, got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pred = count_flow(tuple_t'(in_tdata));
        due_results.push_back(word_typed ? word_want : pred);
      end
      if (out_tvalid && out_tready) begin
        got = flow_result_t'(out_tdata);
        if (due_results.size() == 0) begin
          $display("%0t: result word with nothing expected, got %h", $time, out_tdata);
          error_count++;
        end else begin
          want = due_results.pop_front();
          if (got.flow_index != want.flow_index) begin
            $display("%0t: flow_index expected %0d got %0d", $time,
                     want.flow_index, got.flow_index);
            error_count++;
          end
          if (got.flow_count != want.flow_count) begin
            $display("%0t: flow_count expected %0d got %0d", $time,
                     want.flow_count, got.flow_count);
            error_count++;
          end
          if (got.new_flow != want.new_flow) begin
            $display("%0t: new_flow expected %0d got %0d", $time,
                     want.new_flow, got.new_flow);
            error_count++;
          end
          if (got.dropped != want.dropped) begin
            $display("%0t: dropped expected %0d got %0d", $time,
                     want.dropped, got.dropped);
            error_count++;
          end
          if (got.unique_flows != want.unique_flows) begin
            $display("%0t: unique_flows expected %0d got %0d", $time,
                     want.unique_flows, got.unique_flows);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    tuple_t prev;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (STIM_ROWS[k]) begin
      offer_word(STIM_ROWS[k].t, STIM_ROWS[k].typed, STIM_ROWS[k].r);
    end

    prev = STIM_ROWS[15].t;
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n == 300) hold_req = 1'b1;
      idle_on = !(n >= 900 && n < 1200);
      prev = pick_tuple(prev);
      offer_word(prev, 1'b0, '0);
    end
    in_tvalid <= 1'b0;
    idle_on = 1'b1;

    do @(posedge clk); while (due_results.size() != 0);
    repeat (2 * ftc_pkg::TABLE_ENTRIES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
